// ----- hdl/cube_map_normal_texel_generator_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the cube-map normal texel generator
// Shared concurrent assertion forms. The asserting module supplies clk and rst.
// ----------------------------------------------------------------------------
`ifndef CUBE_MAP_NORMAL_TEXEL_GENERATOR_CORE_ASSERT_SVH
`define CUBE_MAP_NORMAL_TEXEL_GENERATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CMNG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CMNG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/cmng_pkg.sv -----
// ----------------------------------------------------------------------------
// Cube-map normal generator package
// Shared constants, the face code type and the byte packing function.
// ----------------------------------------------------------------------------
package cmng_pkg;

  // Input field widths.
  localparam int FACE_W = 3;
  localparam int IDX_W  = 7;

  // Reciprocal square root format: unsigned, 24 fraction bits.
  localparam int RSQ_FRAC_BITS = 24;
  // The dividend 2^48 needs 49 bits; the quotient fits in 48.
  localparam int NUM_W    = 2 * RSQ_FRAC_BITS + 1;
  localparam int QUO_W    = 2 * RSQ_FRAC_BITS;
  localparam int ROOT_W   = RSQ_FRAC_BITS;
  localparam int SQ_REM_W = ROOT_W + 2;
  localparam logic [NUM_W-1:0] RSQ_NUMERATOR = {1'b1, {QUO_W{1'b0}}};

  // Packing: biased component u + 1.0 fits in 26 bits.
  localparam int PACK_W = RSQ_FRAC_BITS + 2;
  localparam int ONE_FIX = 1 << RSQ_FRAC_BITS;
  localparam int BYTE_W = 8;
  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;

  // Cube face codes; the two remaining codes are unused.
  typedef enum logic [FACE_W-1:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_t;

  // Scale a biased unit component by 255 / 2^25 and saturate to a byte.
  function automatic logic [BYTE_W-1:0] pack_byte(input logic [PACK_W-1:0] biased);
    logic [PACK_W+BYTE_W-1:0] scaled;
    logic [BYTE_W:0]          whole;
    begin
      scaled = {biased, {BYTE_W{1'b0}}} - (PACK_W + BYTE_W)'(biased);
      whole  = scaled[PACK_W+BYTE_W-1:RSQ_FRAC_BITS+1];
      pack_byte = whole[BYTE_W] ? BYTE_MAX : whole[BYTE_W-1:0];
    end
  endfunction

endpackage

// ----- hdl/cmng_front.sv -----
// ----------------------------------------------------------------------------
// Direction front end
// Forms the texel-centre direction for a face and its squared length
// over three register stages.
// ----------------------------------------------------------------------------
module cmng_front
  import cmng_pkg::*;
#(
  parameter int FACE_SIZE = 128,
  parameter int CW        = 9,
  parameter int L2W       = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FACE_W-1:0]     face,
  input  logic [IDX_W-1:0]      column,
  input  logic [IDX_W-1:0]      row,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [CW-1:0]  x_out,
  output logic signed [CW-1:0]  y_out,
  output logic signed [CW-1:0]  z_out,
  output logic                  zero_out,
  output logic [L2W-1:0]        l2_out
);

  localparam int NST = 3;
  localparam int EW  = (CW > IDX_W + 2) ? CW : IDX_W + 2;
  localparam logic [EW-1:0]        MAX_IDX = EW'(FACE_SIZE - 1);
  localparam logic signed [EW-1:0] N_E     = EW'(FACE_SIZE);
  localparam logic signed [CW-1:0] N_C     = CW'(FACE_SIZE);

  logic [NST-1:0] v;
  logic [NST:0]   rdy;

  logic [EW-1:0]        col_e, row_e, col_c, row_c;
  logic signed [EW-1:0] s_e, t_e;
  logic signed [CW-1:0] s_c, t_c, x_c, y_c, z_c;
  logic                 zero_c;

  logic signed [CW-1:0] x0, y0, z0, x1, y1, z1, x2, y2, z2;
  logic                 zero0, zero1, zero2;
  logic signed [2*CW-1:0] px, py, pz;
  logic [L2W-1:0]       sqx, sqy, sqz, l2;

  // Stage occupancy: a stage takes new data when it is empty or drains.
  assign rdy[NST] = !out_stall;
  assign rdy[2]   = !v[2] || rdy[3];
  assign rdy[1]   = !v[1] || rdy[2];
  assign rdy[0]   = !v[0] || rdy[1];
  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      if (rdy[1]) v[1] <= v[0];
      if (rdy[2]) v[2] <= v[1];
    end
  end

  // Clamp the indices and form the doubled texel-centre offsets.
  always_comb begin
    col_e = EW'(column);
    row_e = EW'(row);
    col_c = (col_e > MAX_IDX) ? MAX_IDX : col_e;
    row_c = (row_e > MAX_IDX) ? MAX_IDX : row_e;
    s_e   = $signed(col_c << 1) + $signed(EW'(1)) - N_E;
    t_e   = $signed(row_c << 1) + $signed(EW'(1)) - N_E;
    s_c   = $signed(s_e[CW-1:0]);
    t_c   = $signed(t_e[CW-1:0]);
  end

  // Map the offsets onto the face axes.
  always_comb begin
    zero_c = (face > FACE_NEG_Z);
    unique case (face_t'(face))
      FACE_POS_X: begin x_c = N_C;  y_c = -t_c; z_c = -s_c; end
      FACE_NEG_X: begin x_c = -N_C; y_c = -t_c; z_c = s_c;  end
      FACE_POS_Y: begin x_c = s_c;  y_c = N_C;  z_c = t_c;  end
      FACE_NEG_Y: begin x_c = s_c;  y_c = -N_C; z_c = -t_c; end
      FACE_POS_Z: begin x_c = s_c;  y_c = -t_c; z_c = N_C;  end
      default:    begin x_c = -s_c; y_c = -t_c; z_c = -N_C; end
    endcase
  end

  // Stage 0: the direction vector.
  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      x0    <= x_c;
      y0    <= y_c;
      z0    <= z_c;
      zero0 <= zero_c;
    end
  end

  // Stage 1: squared components.
  assign px = x0 * x0;
  assign py = y0 * y0;
  assign pz = z0 * z0;

  always_ff @(posedge clk) begin
    if (rdy[1] && v[0]) begin
      x1    <= x0;
      y1    <= y0;
      z1    <= z0;
      zero1 <= zero0;
      sqx   <= px[L2W-1:0];
      sqy   <= py[L2W-1:0];
      sqz   <= pz[L2W-1:0];
    end
  end

  // Stage 2: squared length.
  always_ff @(posedge clk) begin
    if (rdy[2] && v[1]) begin
      x2    <= x1;
      y2    <= y1;
      z2    <= z1;
      zero2 <= zero1;
      l2    <= sqx + sqy + sqz;
    end
  end

  assign out_valid = v[2];
  assign x_out     = x2;
  assign y_out     = y2;
  assign z_out     = z2;
  assign zero_out  = zero2;
  assign l2_out    = l2;

endmodule

// ----- hdl/cmng_rsq.sv -----
// ----------------------------------------------------------------------------
// Reciprocal square root pipeline
// Computes floor(2^24 / sqrt(L2)) as the integer square root of
// floor(2^48 / L2): one restoring divide step per stage, then one root
// digit per stage.
// ----------------------------------------------------------------------------
`include "cube_map_normal_texel_generator_core_assert.svh"

module cmng_rsq
  import cmng_pkg::*;
#(
  parameter int CW  = 9,
  parameter int L2W = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [CW-1:0]  x_in,
  input  logic signed [CW-1:0]  y_in,
  input  logic signed [CW-1:0]  z_in,
  input  logic                  zero_in,
  input  logic [L2W-1:0]        l2_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [CW-1:0]  x_out,
  output logic signed [CW-1:0]  y_out,
  output logic signed [CW-1:0]  z_out,
  output logic                  zero_out,
  output logic [ROOT_W-1:0]     root_out
);

  localparam int NDIV = NUM_W;
  localparam int NSQ  = ROOT_W;
  localparam int NST  = NDIV + NSQ;

  logic [NST-1:0] v;
  wire  [NST:0]   rdy;
  wire  [NST-1:0] pv;

  // Direction components ride along with every stage.
  logic signed [CW-1:0] xs [NST];
  logic signed [CW-1:0] ys [NST];
  logic signed [CW-1:0] zs [NST];
  logic                 zf [NST];

  // Divider state.
  logic [L2W-1:0]   drem [NDIV];
  logic [L2W-1:0]   dl2  [NDIV];
  logic [NUM_W-1:0] dquo [NDIV];

  // Square root state.
  logic [SQ_REM_W-1:0] srem  [NSQ];
  logic [ROOT_W-1:0]   sroot [NSQ];
  logic [QUO_W-1:0]    sq    [NSQ];

  // Handshake chain: each stage loads when empty or when the next one loads.
  assign rdy[NST] = !out_stall;
  for (genvar i = 0; i < NST; i++) begin : g_rdy
    assign rdy[i] = !v[i] || rdy[i+1];
    if (i == 0) begin : g_first
      assign pv[i] = in_valid;
    end else begin : g_next
      assign pv[i] = v[i-1];
    end
  end
  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (rdy[i]) v[i] <= pv[i];
      end
    end
  end

  // Restoring division of 2^48 by L2, one quotient bit per stage.
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    logic [L2W-1:0]       rem_prev, l2_prev;
    logic [NUM_W-1:0]     quo_prev;
    logic signed [CW-1:0] x_prev, y_prev, z_prev;
    logic                 zero_prev;
    logic [L2W:0]         shifted, diff;
    logic                 take;

    if (k == 0) begin : g_src
      assign rem_prev  = '0;
      assign quo_prev  = '0;
      assign l2_prev   = l2_in;
      assign x_prev    = x_in;
      assign y_prev    = y_in;
      assign z_prev    = z_in;
      assign zero_prev = zero_in;
    end else begin : g_src
      assign rem_prev  = drem[k-1];
      assign quo_prev  = dquo[k-1];
      assign l2_prev   = dl2[k-1];
      assign x_prev    = xs[k-1];
      assign y_prev    = ys[k-1];
      assign z_prev    = zs[k-1];
      assign zero_prev = zf[k-1];
    end

    assign shifted = {rem_prev, RSQ_NUMERATOR[NUM_W-1-k]};
    assign diff    = shifted - {1'b0, l2_prev};
    assign take    = (shifted >= {1'b0, l2_prev});

    always_ff @(posedge clk) begin
      if (rdy[k] && pv[k]) begin
        drem[k] <= take ? diff[L2W-1:0] : shifted[L2W-1:0];
        dquo[k] <= {quo_prev[NUM_W-2:0], take};
        dl2[k]  <= l2_prev;
        xs[k]   <= x_prev;
        ys[k]   <= y_prev;
        zs[k]   <= z_prev;
        zf[k]   <= zero_prev;
      end
    end
  end

  // Digit-by-digit square root of the quotient, one root bit per stage.
  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    localparam int S = NDIV + j;
    logic [SQ_REM_W-1:0]   rem_prev;
    logic [ROOT_W-1:0]     root_prev;
    logic [QUO_W-1:0]      q_prev;
    logic signed [CW-1:0]  x_prev, y_prev, z_prev;
    logic                  zero_prev;
    logic [SQ_REM_W+1:0]   shifted, trial, diff;
    logic                  take;

    if (j == 0) begin : g_src
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign q_prev    = dquo[NDIV-1][QUO_W-1:0];
    end else begin : g_src
      assign rem_prev  = srem[j-1];
      assign root_prev = sroot[j-1];
      assign q_prev    = sq[j-1];
    end
    assign x_prev    = xs[S-1];
    assign y_prev    = ys[S-1];
    assign z_prev    = zs[S-1];
    assign zero_prev = zf[S-1];

    assign shifted = {rem_prev, q_prev[2*(NSQ-1-j)+1 -: 2]};
    assign trial   = {2'b00, root_prev, 2'b01};
    assign diff    = shifted - trial;
    assign take    = (shifted >= trial);

    always_ff @(posedge clk) begin
      if (rdy[S] && pv[S]) begin
        srem[j]  <= take ? diff[SQ_REM_W-1:0] : shifted[SQ_REM_W-1:0];
        sroot[j] <= {root_prev[ROOT_W-2:0], take};
        sq[j]    <= q_prev;
        xs[S]    <= x_prev;
        ys[S]    <= y_prev;
        zs[S]    <= z_prev;
        zf[S]    <= zero_prev;
      end
    end
  end

  assign out_valid = v[NST-1];
  assign x_out     = xs[NST-1];
  assign y_out     = ys[NST-1];
  assign z_out     = zs[NST-1];
  assign zero_out  = zf[NST-1];
  assign root_out  = sroot[NSQ-1];

  // The divider remainder must stay below the divisor.
  `CMNG_ASSERT_NOW(a_div_rem_below_divisor, v[NDIV-1], drem[NDIV-1] < dl2[NDIV-1], "divider remainder not below divisor")
  // A finished root leaves a remainder of at most twice the root.
  `CMNG_ASSERT_NOW(a_sqrt_rem_bound, v[NST-1], srem[NSQ-1] <= SQ_REM_W'({sroot[NSQ-1], 1'b0}), "square root remainder out of range")
  // An item leaving the divider must arrive in the first root stage.
  `CMNG_ASSERT_NEXT(a_div_to_sqrt_handoff, v[NDIV-1] && rdy[NDIV], v[NDIV], "item lost between divider and square root")

endmodule

// ----- hdl/cmng_pack.sv -----
// ----------------------------------------------------------------------------
// Component packer
// Scales each component by the reciprocal length and packs it into a byte
// over two register stages.
// ----------------------------------------------------------------------------
module cmng_pack
  import cmng_pkg::*;
#(
  parameter int CW = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [CW-1:0]  x_in,
  input  logic signed [CW-1:0]  y_in,
  input  logic signed [CW-1:0]  z_in,
  input  logic                  zero_in,
  input  logic [ROOT_W-1:0]     root_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BYTE_W-1:0]     red,
  output logic [BYTE_W-1:0]     green,
  output logic [BYTE_W-1:0]     blue
);

  localparam int NST = 2;
  localparam int PW  = CW + ROOT_W + 1;
  localparam logic signed [PW-1:0] ONE_P = PW'(ONE_FIX);

  logic [NST-1:0] v;
  logic [NST:0]   rdy;

  logic signed [ROOT_W:0] root_s;
  logic signed [PW-1:0]   ux, uy, uz;
  logic [PACK_W-1:0]      bx, by, bz;
  logic                   zero0;
  logic [BYTE_W-1:0]      red_r, green_r, blue_r;

  assign rdy[NST] = !out_stall;
  assign rdy[1]   = !v[1] || rdy[2];
  assign rdy[0]   = !v[0] || rdy[1];
  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      if (rdy[1]) v[1] <= v[0];
    end
  end

  // Stage 0: unit components in fixed point, biased by one.
  assign root_s = $signed({1'b0, root_in});
  assign ux     = x_in * root_s + ONE_P;
  assign uy     = y_in * root_s + ONE_P;
  assign uz     = z_in * root_s + ONE_P;

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      bx    <= ux[PW-1] ? '0 : ux[PACK_W-1:0];
      by    <= uy[PW-1] ? '0 : uy[PACK_W-1:0];
      bz    <= uz[PW-1] ? '0 : uz[PACK_W-1:0];
      zero0 <= zero_in;
    end
  end

  // Stage 1: byte packing; unused faces give zero.
  always_ff @(posedge clk) begin
    if (rdy[1] && v[0]) begin
      red_r   <= zero0 ? '0 : pack_byte(bx);
      green_r <= zero0 ? '0 : pack_byte(by);
      blue_r  <= zero0 ? '0 : pack_byte(bz);
    end
  end

  assign out_valid = v[1];
  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;

endmodule

// ----- hdl/cube_map_normal_texel_generator_core.sv -----
// ----------------------------------------------------------------------------
// Cube-map normal texel generator
// Takes one texel item (face, column, row) per cycle while req_stall is low
// and returns the packed unit direction through the texel centre as red,
// green and blue bytes, one result per item and in order. The front end
// forms the direction and its squared length, 49 one-bit restoring divide
// stages and 24 one-digit square root stages give the reciprocal length,
// and the packer scales and packs. A stall on the result side backs up only
// as far as the first empty stage, so items keep entering while
// bubbles remain.
// Face codes 6 and 7 return zero bytes; a column or row beyond the face
// edge is clamped to the last texel.
// ----------------------------------------------------------------------------
`include "cube_map_normal_texel_generator_core_assert.svh"

module cube_map_normal_texel_generator_core
  import cmng_pkg::*;
#(
  parameter int FACE_SIZE = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [FACE_W-1:0] face,
  input  logic [IDX_W-1:0]  column,
  input  logic [IDX_W-1:0]  row,
  output logic              texel_valid,
  input  logic              texel_stall,
  output logic [BYTE_W-1:0] red,
  output logic [BYTE_W-1:0] green,
  output logic [BYTE_W-1:0] blue
);

  // Component magnitudes reach FACE_SIZE; three squares fit in L2W bits.
  localparam int CW  = $clog2(FACE_SIZE) + 2;
  localparam int L2W = 2 * $clog2(FACE_SIZE) + 2;

  logic                 f_valid, f_stall;
  logic signed [CW-1:0] f_x, f_y, f_z;
  logic                 f_zero;
  logic [L2W-1:0]       f_l2;

  logic                 r_valid, r_stall;
  logic signed [CW-1:0] r_x, r_y, r_z;
  logic                 r_zero;
  logic [ROOT_W-1:0]    r_root;

  // Direction and squared length.
  cmng_front #(
    .FACE_SIZE (FACE_SIZE),
    .CW        (CW),
    .L2W       (L2W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_valid),
    .in_stall  (req_stall),
    .face      (face),
    .column    (column),
    .row       (row),
    .out_valid (f_valid),
    .out_stall (f_stall),
    .x_out     (f_x),
    .y_out     (f_y),
    .z_out     (f_z),
    .zero_out  (f_zero),
    .l2_out    (f_l2)
  );

  // Reciprocal length.
  cmng_rsq #(
    .CW  (CW),
    .L2W (L2W)
  ) u_rsq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_stall  (f_stall),
    .x_in      (f_x),
    .y_in      (f_y),
    .z_in      (f_z),
    .zero_in   (f_zero),
    .l2_in     (f_l2),
    .out_valid (r_valid),
    .out_stall (r_stall),
    .x_out     (r_x),
    .y_out     (r_y),
    .z_out     (r_z),
    .zero_out  (r_zero),
    .root_out  (r_root)
  );

  // Scale and pack.
  cmng_pack #(
    .CW (CW)
  ) u_pack (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (r_valid),
    .in_stall  (r_stall),
    .x_in      (r_x),
    .y_in      (r_y),
    .z_in      (r_z),
    .zero_in   (r_zero),
    .root_in   (r_root),
    .out_valid (texel_valid),
    .out_stall (texel_stall),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  // The input side can only be held off when the whole pipe is full.
  `CMNG_ASSERT_NOW(a_stall_only_when_full, req_stall, texel_valid && texel_stall, "input stalled while pipeline has room")

endmodule
